### src/lossw_pkg.sv
// shared types, widths and constants of the line-of-sight ray sweep
`default_nettype none

package lossw_pkg;

  // field and datapath widths
  localparam int OFS_W      = 14;
  localparam int ELEV_W     = 16;
  localparam int SRC_W      = 17;
  localparam int CELL_W     = 23;
  localparam int RANGE_W    = 13;
  localparam int INV_W      = 20;
  localparam int DIST_W     = 40;
  localparam int STEP_W     = 24;
  localparam int LIM_W      = 36;
  localparam int SLOPE_W    = 48;
  localparam int QUOT_W     = 47;
  localparam int MAG_W      = 41;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  localparam int MAX_RADIUS_DEFAULT = 4096;

  // no-data threshold in meters
  localparam logic signed [ELEV_W-1:0] NODATA_LIMIT = -16'sd9000;
  // sqrt2 as Q1.30
  localparam logic [30:0] SQRT2_Q30 = 31'd1518500250;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_ELEV  = 3'd0,
    CFG_CELL_SIZE = 3'd1,
    CFG_RANGE     = 3'd2,
    CFG_CURV_ON   = 3'd3,
    CFG_INV_2R    = 3'd4
  } cfg_idx_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIM,
    ST_BRES,
    ST_SQ2,
    ST_MDL,
    ST_MDH,
    ST_MSS,
    ST_MKH,
    ST_MKL,
    ST_DIST,
    ST_DIV,
    ST_JUDGE,
    ST_FIN
  } st_t;

  // divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### src/lossw_if.sv
// handshake channel interfaces of the line-of-sight ray sweep
`default_nettype none

interface lossw_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [lossw_pkg::OFS_W-1:0]    end_row_offset;
  logic signed [lossw_pkg::OFS_W-1:0]    end_col_offset;
  logic signed [lossw_pkg::ELEV_W-1:0]   elevation;
  modport source (output valid, mode, end_row_offset, end_col_offset, elevation,
                  input ready);
  modport sink (input valid, mode, end_row_offset, end_col_offset, elevation,
                output ready);
endinterface

interface lossw_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  visible;
  logic signed [lossw_pkg::OFS_W-1:0]    judged_row_offset;
  logic signed [lossw_pkg::OFS_W-1:0]    judged_col_offset;
  logic signed [lossw_pkg::OFS_W-1:0]    request_row_offset;
  logic signed [lossw_pkg::OFS_W-1:0]    request_col_offset;
  logic                                  ray_done;
  modport source (output valid, visible, judged_row_offset, judged_col_offset,
                  request_row_offset, request_col_offset, ray_done, input ready);
  modport sink (input valid, visible, judged_row_offset, judged_col_offset,
                request_row_offset, request_col_offset, ray_done, output ready);
endinterface

interface lossw_cfg_if;
  logic                                  valid;
  logic                                  ready;
  logic [lossw_pkg::CFG_IDX_W-1:0]       index;
  logic [lossw_pkg::CFG_DATA_W-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/lossw_div.sv
// radix-2 restoring divider for the Q.24 slope, with saturation
`default_nettype none

module lossw_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [lossw_pkg::MAG_W-1:0]   mag,
  input  wire logic [lossw_pkg::DIST_W-1:0]  den,
  output lossw_pkg::div_stat_t               stat,
  output logic [lossw_pkg::QUOT_W-1:0]       quot
);

  localparam int CNT_W = $clog2(lossw_pkg::QUOT_W + 1);
  localparam int CMP_W = lossw_pkg::DIST_W + 24;

  logic [CNT_W-1:0]                cnt_r;
  logic                            busy_r;
  logic                            done_r;
  logic [lossw_pkg::DIST_W-1:0]    rem_r;
  logic [lossw_pkg::DIST_W-1:0]    den_r;
  logic [lossw_pkg::QUOT_W-1:0]    sh_r;

  logic [lossw_pkg::DIST_W:0]      rs;
  logic [lossw_pkg::DIST_W:0]      diff;
  logic                            ge;
  logic                            sat;

  // quotient would not fit 47 bits
  assign sat = {(CMP_W - lossw_pkg::MAG_W)'(0), mag} >= {1'b0, den, 23'b0};

  // one quotient bit per cycle
  assign rs   = {rem_r, sh_r[lossw_pkg::QUOT_W-1]};
  assign diff = rs - {1'b0, den_r};
  assign ge   = rs >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      // done pulses on a saturated start or after the last quotient bit
      done_r <= start ? sat : (busy_r && (cnt_r == CNT_W'(1)));
      if (start) begin
        den_r <= den;
        if (sat) begin
          sh_r   <= '1;
        end else begin
          rem_r  <= {(lossw_pkg::DIST_W - 18)'(0), mag[40:23]};
          sh_r   <= {mag[22:0], 24'b0};
          cnt_r  <= CNT_W'(lossw_pkg::QUOT_W);
          busy_r <= 1'b1;
        end
      end else if (busy_r) begin
        rem_r <= ge ? diff[lossw_pkg::DIST_W-1:0] : rs[lossw_pkg::DIST_W-1:0];
        sh_r  <= {sh_r[lossw_pkg::QUOT_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sh_r;

endmodule

`default_nettype wire

### src/line_of_sight_ray_sweep_unit.sv
// top level: bresenham ray walker with max-slope visibility test
//
//   channel | dir | beat
//   in_ch   | in  | start (end offsets) or elevation sample
//   out_ch  | out | one verdict and next request per input beat
//   cfg_ch  | in  | register index and write data, always ready
//
// starts and samples run through the sequencer states: one shared 32x32
// multiplier walks the range limit, sqrt2 step and five curvature products,
// and the slope divider retires one quotient bit per cycle (47 bits).
// in_ready is high only while the sequencer is idle; a waiting result sits in
// the output register and holds the sequencer at its last step until taken.
// reset is synchronous and needs no clearing pass.
`default_nettype none

module line_of_sight_ray_sweep_unit #(
  parameter int MAX_RADIUS = lossw_pkg::MAX_RADIUS_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lossw_in_if.sink   in_ch,
  lossw_out_if.source out_ch,
  lossw_cfg_if.sink  cfg_ch
);

  localparam logic [15:0] MaxRad = 16'(MAX_RADIUS);

  // configuration registers
  logic signed [lossw_pkg::SRC_W-1:0]  src_elev_r;
  logic [lossw_pkg::CELL_W-1:0]        cell_size_r;
  logic [lossw_pkg::RANGE_W-1:0]       range_r;
  logic                                curv_r;
  logic [lossw_pkg::INV_W-1:0]         inv_r;

  // ray state
  lossw_pkg::st_t                      state_r, state_nxt;
  logic signed [14:0]                  err_r;
  logic signed [lossw_pkg::OFS_W-1:0]  pos_row_r, pos_col_r;
  logic signed [lossw_pkg::OFS_W-1:0]  tgt_row_r, tgt_col_r;
  logic [lossw_pkg::OFS_W-1:0]         adx_r, ady_r;
  logic [lossw_pkg::DIST_W-1:0]        dist_r;
  logic [lossw_pkg::DIST_W-1:0]        drop_r;
  logic signed [lossw_pkg::SLOPE_W-1:0] best_r;
  logic                                active_r;
  logic [lossw_pkg::STEP_W-1:0]        step_r;
  logic [lossw_pkg::LIM_W-1:0]         lim_r;
  logic [63:0]                         acc_r;
  logic [52:0]                         t_r;
  logic                                neg_r;
  logic                                vis_r;
  logic signed [lossw_pkg::OFS_W-1:0]  jr_r, jc_r;

  // output register
  logic                                out_valid_r;
  logic                                out_vis_r;
  logic signed [lossw_pkg::OFS_W-1:0]  out_jr_r, out_jc_r, out_qr_r, out_qc_r;
  logic                                out_done_r;

  // shared multiplier
  logic [31:0]                         mul_a, mul_b;
  logic [63:0]                         prod;

  // divider
  logic                                div_start;
  lossw_pkg::div_stat_t                div_stat;
  logic [lossw_pkg::QUOT_W-1:0]        quot;

  logic                                in_acc;
  logic [lossw_pkg::CELL_W-1:0]        cs_eff;
  logic [lossw_pkg::RANGE_W-1:0]       rng;
  logic [lossw_pkg::OFS_W-1:0]         in_adx, in_ady;
  logic                                start_zero;
  logic                                nodata;
  logic signed [17:0]                  elev_diff;
  logic signed [41:0]                  num;
  logic [lossw_pkg::MAG_W-1:0]         num_mag;
  logic signed [15:0]                  e2;
  logic                                mv_row, mv_col;
  logic signed [lossw_pkg::SLOPE_W-1:0] slope;
  logic                                at_target;
  logic                                out_free;
  logic [53:0]                         sq2_rnd;
  logic [52:0]                         kl_sum;
  logic [40:0]                         drop_sum;
  logic [lossw_pkg::DIST_W-1:0]        dist_sum;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign cs_eff   = (cell_size_r == '0) ? lossw_pkg::CELL_W'(1) : cell_size_r;
  assign rng      = ({3'b0, range_r} < MaxRad) ? range_r : MaxRad[lossw_pkg::RANGE_W-1:0];

  // start decode
  assign in_adx = in_ch.end_row_offset[13] ? 14'(-in_ch.end_row_offset)
                                           : in_ch.end_row_offset;
  assign in_ady = in_ch.end_col_offset[13] ? 14'(-in_ch.end_col_offset)
                                           : in_ch.end_col_offset;
  assign start_zero = (in_ch.end_row_offset == '0) && (in_ch.end_col_offset == '0);

  // sample numerator: (elev - source) * 4096 - drop
  assign nodata    = in_ch.elevation < lossw_pkg::NODATA_LIMIT;
  assign elev_diff = 18'(in_ch.elevation) - 18'(src_elev_r);
  assign num       = {{12{elev_diff[17]}}, elev_diff, 12'b0} - {2'b0, drop_r};
  assign num_mag   = num[41] ? 41'(-num) : num[40:0];

  // bresenham step decision
  assign e2     = {err_r, 1'b0};
  assign mv_row = e2 > -$signed({2'b0, ady_r});
  assign mv_col = e2 < $signed({2'b0, adx_r});

  assign slope     = neg_r ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign at_target = (pos_row_r == tgt_row_r) && (pos_col_r == tgt_col_r);

  assign prod     = 64'(mul_a) * 64'(mul_b);
  assign sq2_rnd  = prod[53:0] + 54'(1 << 29);
  assign kl_sum   = t_r + 53'(prod[51:32]);
  assign drop_sum = {1'b0, drop_r} + 41'(kl_sum[52:20]);
  assign dist_sum = dist_r + lossw_pkg::DIST_W'(step_r);

  lossw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .mag   (num_mag),
    .den   (dist_r),
    .stat  (div_stat),
    .quot  (quot)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lossw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (!in_ch.mode)
            state_nxt = start_zero ? lossw_pkg::ST_FIN : lossw_pkg::ST_LIM;
          else if (!active_r || nodata)
            state_nxt = lossw_pkg::ST_FIN;
          else
            state_nxt = lossw_pkg::ST_DIV;
        end
      end
      lossw_pkg::ST_LIM:  state_nxt = lossw_pkg::ST_BRES;
      lossw_pkg::ST_BRES: begin
        if (mv_row && mv_col)
          state_nxt = lossw_pkg::ST_SQ2;
        else
          state_nxt = curv_r ? lossw_pkg::ST_MDL : lossw_pkg::ST_DIST;
      end
      lossw_pkg::ST_SQ2:  state_nxt = curv_r ? lossw_pkg::ST_MDL : lossw_pkg::ST_DIST;
      lossw_pkg::ST_MDL:  state_nxt = lossw_pkg::ST_MDH;
      lossw_pkg::ST_MDH:  state_nxt = lossw_pkg::ST_MSS;
      lossw_pkg::ST_MSS:  state_nxt = lossw_pkg::ST_MKH;
      lossw_pkg::ST_MKH:  state_nxt = lossw_pkg::ST_MKL;
      lossw_pkg::ST_MKL:  state_nxt = lossw_pkg::ST_DIST;
      lossw_pkg::ST_DIST: state_nxt = lossw_pkg::ST_FIN;
      lossw_pkg::ST_DIV: begin
        if (div_stat.done)
          state_nxt = lossw_pkg::ST_JUDGE;
      end
      lossw_pkg::ST_JUDGE: state_nxt = at_target ? lossw_pkg::ST_FIN : lossw_pkg::ST_LIM;
      lossw_pkg::ST_FIN: begin
        if (out_free)
          state_nxt = lossw_pkg::ST_IDLE;
      end
      default: state_nxt = lossw_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: multiplier operands, divider kick, input ready
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    unique case (state_r)
      lossw_pkg::ST_IDLE: begin
        div_start = in_acc && in_ch.mode && active_r && !nodata;
      end
      lossw_pkg::ST_LIM: begin
        mul_a = 32'(rng);
        mul_b = 32'(cs_eff);
      end
      lossw_pkg::ST_SQ2: begin
        mul_a = 32'(cs_eff);
        mul_b = 32'(lossw_pkg::SQRT2_Q30);
      end
      lossw_pkg::ST_MDL: begin
        mul_a = 32'(dist_r[19:0]);
        mul_b = 32'(step_r);
      end
      lossw_pkg::ST_MDH: begin
        mul_a = 32'(dist_r[39:20]);
        mul_b = 32'(step_r);
      end
      lossw_pkg::ST_MSS: begin
        mul_a = 32'(step_r);
        mul_b = 32'(step_r);
      end
      lossw_pkg::ST_MKH: begin
        mul_a = acc_r[63:32];
        mul_b = 32'(inv_r);
      end
      lossw_pkg::ST_MKL: begin
        mul_a = acc_r[31:0];
        mul_b = 32'(inv_r);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign in_ch.ready  = (state_r == lossw_pkg::ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_elev_r  <= '0;
      cell_size_r <= 23'd122880;
      range_r     <= 13'd4096;
      curv_r      <= 1'b1;
      inv_r       <= 20'd86300;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        lossw_pkg::CFG_SRC_ELEV:  src_elev_r  <= cfg_ch.data[lossw_pkg::SRC_W-1:0];
        lossw_pkg::CFG_CELL_SIZE: cell_size_r <= cfg_ch.data;
        lossw_pkg::CFG_RANGE:     range_r     <= cfg_ch.data[lossw_pkg::RANGE_W-1:0];
        lossw_pkg::CFG_CURV_ON:   curv_r      <= cfg_ch.data[0];
        lossw_pkg::CFG_INV_2R:    inv_r       <= cfg_ch.data[lossw_pkg::INV_W-1:0];
        default: begin
          curv_r <= curv_r;
        end
      endcase
    end
  end

  // ray datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= lossw_pkg::ST_IDLE;
      err_r     <= '0;
      pos_row_r <= '0;
      pos_col_r <= '0;
      tgt_row_r <= '0;
      tgt_col_r <= '0;
      adx_r     <= '0;
      ady_r     <= '0;
      dist_r    <= '0;
      drop_r    <= '0;
      best_r    <= {1'b1, {(lossw_pkg::SLOPE_W-1){1'b0}}};
      active_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        lossw_pkg::ST_IDLE: begin
          if (in_acc) begin
            vis_r <= 1'b0;
            jr_r  <= '0;
            jc_r  <= '0;
            if (!in_ch.mode) begin
              tgt_row_r <= in_ch.end_row_offset;
              tgt_col_r <= in_ch.end_col_offset;
              adx_r     <= in_adx;
              ady_r     <= in_ady;
              err_r     <= 15'({1'b0, in_adx}) - 15'({1'b0, in_ady});
              pos_row_r <= '0;
              pos_col_r <= '0;
              dist_r    <= '0;
              drop_r    <= '0;
              best_r    <= {1'b1, {(lossw_pkg::SLOPE_W-1){1'b0}}};
              active_r  <= !start_zero;
            end else if (active_r) begin
              jr_r  <= pos_row_r;
              jc_r  <= pos_col_r;
              neg_r <= num[41];
              if (nodata)
                active_r <= 1'b0;
            end
          end
        end
        lossw_pkg::ST_LIM: begin
          lim_r <= prod[lossw_pkg::LIM_W-1:0];
        end
        lossw_pkg::ST_BRES: begin
          err_r <= err_r - (mv_row ? 15'({1'b0, ady_r}) : 15'(0))
                         + (mv_col ? 15'({1'b0, adx_r}) : 15'(0));
          if (mv_row)
            pos_row_r <= pos_row_r + ((tgt_row_r > 0) ? 14'sd1 : -14'sd1);
          if (mv_col)
            pos_col_r <= pos_col_r + ((tgt_col_r > 0) ? 14'sd1 : -14'sd1);
          step_r <= lossw_pkg::STEP_W'(cs_eff);
        end
        lossw_pkg::ST_SQ2: step_r <= sq2_rnd[53:30];
        lossw_pkg::ST_MDL: acc_r  <= prod;
        lossw_pkg::ST_MDH: acc_r  <= acc_r + {prod[43:0], 20'b0};
        lossw_pkg::ST_MSS: acc_r  <= {acc_r[62:0], 1'b0} + prod;
        lossw_pkg::ST_MKH: t_r    <= 53'(prod[51:0]) + 53'(1 << 19);
        lossw_pkg::ST_MKL: drop_r <= drop_sum[40] ? '1 : drop_sum[39:0];
        lossw_pkg::ST_DIST: begin
          dist_r   <= dist_sum;
          active_r <= dist_sum <= lossw_pkg::DIST_W'(lim_r);
        end
        lossw_pkg::ST_JUDGE: begin
          if (slope >= best_r) begin
            vis_r  <= 1'b1;
            best_r <= slope;
          end
          if (at_target)
            active_r <= 1'b0;
        end
        default: begin
          vis_r <= vis_r;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == lossw_pkg::ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
        out_vis_r   <= vis_r;
        out_jr_r    <= jr_r;
        out_jc_r    <= jc_r;
        out_qr_r    <= active_r ? pos_row_r : '0;
        out_qc_r    <= active_r ? pos_col_r : '0;
        out_done_r  <= !active_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.visible            = out_vis_r;
  assign out_ch.judged_row_offset  = out_jr_r;
  assign out_ch.judged_col_offset  = out_jc_r;
  assign out_ch.request_row_offset = out_qr_r;
  assign out_ch.request_col_offset = out_qc_r;
  assign out_ch.ray_done           = out_done_r;

endmodule

`default_nettype wire

### src/lossw_checker.sv
// port-level assertions for the ray sweep top level, with its bind
`default_nettype none

module lossw_checker (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                in_valid,
  input wire logic                                in_ready,
  input wire logic                                out_valid,
  input wire logic                                out_ready,
  input wire logic                                out_ray_done,
  input wire logic signed [lossw_pkg::OFS_W-1:0]  out_req_row,
  input wire logic signed [lossw_pkg::OFS_W-1:0]  out_req_col
);

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // one beat at a time: ready falls after an accepted beat
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat accepted while an item is in work");

  // a finished ray asks for nothing
  a_done_no_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ray_done |-> out_req_row == '0 && out_req_col == '0)
    else $error("request shown on a finished ray");

  // a live ray never asks for the observer cell
  a_req_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ray_done |-> out_req_row != '0 || out_req_col != '0)
    else $error("request points at the observer cell");

endmodule

bind line_of_sight_ray_sweep_unit lossw_checker u_lossw_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_ray_done (out_ch.ray_done),
  .out_req_row  (out_ch.request_row_offset),
  .out_req_col  (out_ch.request_col_offset)
);

`default_nettype wire

### test/lossw_tb_pkg.sv
// testbench-only marker package kept empty of logic; shared types come from lossw_pkg
`timescale 1ns / 1ps
package lossw_tb_pkg;
  localparam int TB_PERIOD = 20;
endpackage

### test/line_of_sight_ray_sweep_unit_tb.sv
// testbench of the line-of-sight ray sweep: random and directed rays checked against a predictor
`timescale 1ns / 1ps

module line_of_sight_ray_sweep_unit_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  lossw_in_if  in_ch ();
  lossw_out_if out_ch ();
  lossw_cfg_if cfg_ch ();

  line_of_sight_ray_sweep_unit dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  always #(lossw_tb_pkg::TB_PERIOD / 2) clk = ~clk;

  // expected verdict beat
  typedef struct packed {
    logic              visible;
    logic signed [13:0] jr;
    logic signed [13:0] jc;
    logic signed [13:0] rr;
    logic signed [13:0] rc;
    logic              done;
  } verdict_t;

  verdict_t verdict_q[$];

  // predictor copy of registers
  longint src_elev, cell_sz, range_c, curv_on, inv_2r;
  // predictor copy of ray state
  longint err_acc, pos_r, pos_c, tgt_r, tgt_c;
  longint unsigned dist_acc, drop_acc;
  longint best_s;
  bit     walking;

  int errors = 0;
  int cycles = 0;
  bit timed_out = 0;
  longint unsigned out_beats = 0;

  function automatic longint unsigned drop_step(longint unsigned x, longint unsigned k);
    longint unsigned hi, lo, a;
    hi = x >> 32;
    lo = x & 64'hFFFF_FFFF;
    a = hi * k + (64'd1 << 19) + ((lo * k) >> 32);
    return a >> 20;
  endfunction

  // one bresenham step; returns 1 if still inside range
  function automatic bit walk_step();
    longint adx, ady, sr, sc, e2;
    bit mr, mc;
    longint unsigned cs, stp, rng;
    adx = tgt_r < 0 ? -tgt_r : tgt_r;
    ady = tgt_c < 0 ? -tgt_c : tgt_c;
    sr = tgt_r > 0 ? 1 : -1;
    sc = tgt_c > 0 ? 1 : -1;
    e2 = 2 * err_acc;
    mr = e2 > -ady;
    mc = e2 < adx;
    cs = cell_sz != 0 ? cell_sz : 1;
    if (mr) begin
      err_acc -= ady;
      pos_r += sr;
    end
    if (mc) begin
      err_acc += adx;
      pos_c += sc;
    end
    stp = (mr && mc) ? ((cs * 64'd1518500250 + (64'd1 << 29)) >> 30) : cs;
    if (curv_on != 0) begin
      drop_acc += drop_step(2 * dist_acc * stp + stp * stp, inv_2r);
      if (drop_acc > 64'hFF_FFFF_FFFF) drop_acc = 64'hFF_FFFF_FFFF;
    end
    dist_acc += stp;
    rng = range_c < 4096 ? range_c : 4096;
    return dist_acc <= rng * cs;
  endfunction

  function automatic longint slope_div(longint num, longint unsigned den);
    bit neg;
    longint unsigned mag, q, r;
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= (den << 23)) q = 64'h7FFF_FFFF_FFFF;
    else begin
      q = mag / den;
      r = mag % den;
      for (int i = 0; i < 24; i++) begin
        r <<= 1;
        q <<= 1;
        if (r >= den) begin
          r -= den;
          q |= 1;
        end
      end
    end
    return neg ? -longint'(q) : longint'(q);
  endfunction

  // predict the verdict of one input beat
  function automatic verdict_t judge_beat(bit mode, logic signed [13:0] er,
                                          logic signed [13:0] ec, logic signed [15:0] el);
    verdict_t v;
    longint num, s;
    v = '0;
    if (!mode) begin
      tgt_r = longint'(er);
      tgt_c = longint'(ec);
      err_acc = (tgt_r < 0 ? -tgt_r : tgt_r) - (tgt_c < 0 ? -tgt_c : tgt_c);
      pos_r = 0;
      pos_c = 0;
      dist_acc = 0;
      drop_acc = 0;
      best_s = -(64'sd1 <<< 47);
      walking = (tgt_r != 0 || tgt_c != 0) && walk_step();
    end else if (walking) begin
      v.jr = 14'(pos_r);
      v.jc = 14'(pos_c);
      if (el < -9000) walking = 0;
      else begin
        num = (longint'(el) - src_elev) * 4096 - longint'(drop_acc);
        s = slope_div(num, dist_acc);
        if (s >= best_s) begin
          v.visible = 1;
          best_s = s;
        end
        if (pos_r == tgt_r && pos_c == tgt_c) walking = 0;
        else walking = walk_step();
      end
    end
    v.done = !walking;
    if (walking) begin
      v.rr = 14'(pos_r);
      v.rc = 14'(pos_c);
    end
    return v;
  endfunction

  // send one input beat after a random gap; valid stays up until the next gap
  task automatic send_beat(bit mode, logic signed [13:0] er, logic signed [13:0] ec,
                           logic signed [15:0] el);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.end_row_offset <= er;
    in_ch.end_col_offset <= ec;
    in_ch.elevation <= el;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    verdict_q.insert(verdict_q.size(), judge_beat(mode, er, ec, el));
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic write_reg(lossw_pkg::cfg_idx_t idx, longint val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val[22:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    case (idx)
      lossw_pkg::CFG_SRC_ELEV:  src_elev = longint'(signed'(val[16:0]));
      lossw_pkg::CFG_CELL_SIZE: cell_sz = val & 23'h7F_FFFF;
      lossw_pkg::CFG_RANGE:     range_c = val & 13'h1FFF;
      lossw_pkg::CFG_CURV_ON:   curv_on = val & 1;
      lossw_pkg::CFG_INV_2R:    inv_2r = val & 20'hF_FFFF;
      default: ;
    endcase
  endtask

  task automatic set_all(longint se, longint cs, longint rc, longint co, longint ir);
    drain();
    write_reg(lossw_pkg::CFG_SRC_ELEV, se);
    write_reg(lossw_pkg::CFG_CELL_SIZE, cs);
    write_reg(lossw_pkg::CFG_RANGE, rc);
    write_reg(lossw_pkg::CFG_CURV_ON, co);
    write_reg(lossw_pkg::CFG_INV_2R, ir);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_elev();
    case ($urandom_range(0, 9))
      0: return 16'(-$urandom_range(9001, 32768));
      1: return 16'sd32767;
      2: return -16'sd9000;
      default: return 16'($urandom_range(0, 3000)) - 16'sd500;
    endcase
  endfunction

  // walk one ray with random terrain until it ends or max_len samples are sent
  task automatic sweep_ray(logic signed [13:0] er, logic signed [13:0] ec, int max_len);
    int n;
    send_beat(1'b0, er, ec, 16'($urandom));
    n = 0;
    while (walking && n < max_len) begin
      send_beat(1'b1, 14'($urandom), 14'($urandom), rand_elev());
      n++;
    end
  endtask

  task automatic test_directed();
    send_beat(1'b1, 14'sd0, 14'sd0, 16'sd100);        // sample with no ray
    send_beat(1'b0, 14'sd0, 14'sd0, 16'sd0);          // end at observer
    sweep_ray(14'sd3, 14'sd0, 5);
    sweep_ray(-14'sd2, -14'sd2, 5);
    send_beat(1'b0, 14'sd4096, -14'sd4096, -16'sd1);  // extremes, abandoned
    send_beat(1'b1, 14'sd0, 14'sd0, 16'sd32767);
    send_beat(1'b1, 14'sd0, 14'sd0, -16'sd32768);     // no-data ends ray
    send_beat(1'b0, -14'sd4096, 14'sd4096, 16'sd0);
    send_beat(1'b1, -14'sd1, 14'sd1, -16'sd9000);
    send_beat(1'b0, 14'sd1, 14'sd5, 16'sd0);          // start during a ray
    send_beat(1'b1, 14'sd0, 14'sd0, -16'sd9001);
  endtask

  task automatic test_limits();
    set_all(40000, 0, 0, 0, 0);       // zero cell and zero range
    send_beat(1'b0, 14'sd1, 14'sd1, 16'sd0);
    set_all(-9000, 1, 1, 1, 1048575);
    sweep_ray(14'sd5, 14'sd3, 4);
    set_all(-9000, 4194304, 2, 1, 1048575);
    sweep_ray(-14'sd7, 14'sd7, 8);
    set_all(0, 8388607, 8191, 1, 1048575);
    sweep_ray(14'sd20, -14'sd9, 25);
  endtask

  task automatic test_random();
    int k;
    int lens[3] = '{40, 400, 4096};
    k = 0;
    while (k < 1100) begin
      if (k % 250 == 0)
        set_all($urandom_range(0, 49000) - 9000, $urandom_range(1, 4194304),
                $urandom_range(1, 8191), $urandom_range(0, 1), $urandom_range(0, 1048575));
      if ($urandom_range(0, 7) == 0) begin
        send_beat(1'($urandom), 14'($urandom), 14'($urandom), 16'($urandom));
        k++;
      end else begin
        int sp;
        sp = lens[($urandom_range(0, 19) == 0) ? 1 : 0];
        sweep_ray(14'($urandom_range(0, 2 * sp)) - 14'(sp),
                  14'($urandom_range(0, 2 * sp)) - 14'(sp), $urandom_range(1, 30));
        k += 8;
      end
    end
  endtask

  // consumer: random stall then check each beat
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(out_ch.valid && rst_n)) @(posedge clk);
      begin
        verdict_t got, want;
        got = '{out_ch.visible, out_ch.judged_row_offset, out_ch.judged_col_offset,
                out_ch.request_row_offset, out_ch.request_col_offset, out_ch.ray_done};
        if (verdict_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat %p", got);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("beat %0d mismatch exp %p got %p", out_beats, want, got);
          end
        end
        out_beats++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("[line_of_sight_ray_sweep_unit] ERROR");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = 1'b0;
    in_ch.end_row_offset = '0;
    in_ch.end_col_offset = '0;
    in_ch.elevation = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = lossw_pkg::CFG_SRC_ELEV;
    cfg_ch.data = '0;
    src_elev = 0; cell_sz = 122880; range_c = 4096; curv_on = 1; inv_2r = 86300;
    err_acc = 0; pos_r = 0; pos_c = 0; tgt_r = 0; tgt_c = 0;
    dist_acc = 0; drop_acc = 0; best_s = -(64'sd1 <<< 47); walking = 0;
    repeat (12) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_limits();
    test_random();
    drain();
    if (errors == 0 && verdict_q.size() == 0) $display("[line_of_sight_ray_sweep_unit] OK");
    else $display("[line_of_sight_ray_sweep_unit] ERROR");
    $finish;
  end
endmodule
